// ===== src/tccw_pkg.sv =====
package tccw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_ATTR = 1'b0;
    localparam logic REG_TAB  = 1'b1;

    localparam logic [7:0] ATTR_RESET = 8'h0F;
    localparam logic [3:0] TAB_RESET  = 4'd4;
    localparam logic [3:0] TAB_MAX    = 4'd8;

    // Cell words and special bytes
    localparam logic [15:0] BLANK_CELL = 16'h0F20;
    localparam logic [7:0]  CHAR_BS    = 8'd8;
    localparam logic [7:0]  CHAR_TAB   = 8'd9;
    localparam logic [7:0]  CHAR_NL    = 8'd10;
    localparam logic [7:0]  CHAR_SPACE = 8'h20;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Operation kinds passed from front to back
    localparam logic [1:0] OP_PUT       = 2'd0;
    localparam logic [1:0] OP_NEWLINE   = 2'd1;
    localparam logic [1:0] OP_BACKSPACE = 2'd2;
    localparam logic [1:0] OP_READ      = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } cmd_item_t;

    typedef struct packed {
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [10:0] cursor_position;
        logic [15:0] read_data;
        logic        scrolled;
    } rsp_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_code;
        logic [3:0] count;
        logic [4:0] read_row;
        logic [6:0] read_col;
        logic       read_oob;
    } op_t;

endpackage

// ===== src/tccw_ram.sv =====
module tccw_ram
    #(
        parameter int WIDTH = 16,
        parameter int DEPTH = 256,
        localparam int AW = $clog2(DEPTH)
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/tccw_front.sv =====
module tccw_front
    import tccw_pkg::*;
    #(
        parameter int ROWS    = ROWS_DEF,
        parameter int COLUMNS = COLUMNS_DEF
    )
    (
        input  logic      clk,
        input  logic      rst_n,
        input  logic      cmd_valid,
        output logic      cmd_ready,
        input  cmd_item_t cmd,
        input  logic [3:0] tab_width,
        input  logic      hold,
        output logic      op_valid,
        output op_t       op,
        input  logic      op_pop
    );

    localparam logic [1:0] Q_FULL = 2'd2;

    op_t        op_in;
    op_t        q_mem_reg [2];
    logic       q_wr_reg, q_wr_next;
    logic       q_rd_reg, q_rd_next;
    logic [1:0] q_count_reg, q_count_next;
    logic       push;

    // Classify the incoming transaction
    always_comb
    begin
        op_in.kind      = OP_PUT;
        op_in.char_code = cmd.char_code;
        op_in.count     = 4'd1;
        op_in.read_row  = cmd.read_row;
        op_in.read_col  = cmd.read_col;
        op_in.read_oob  = (32'(cmd.read_row) >= ROWS) || (32'(cmd.read_col) >= COLUMNS);
        if (cmd.func == FUNC_READ)
        begin
            op_in.kind = OP_READ;
        end
        else
        begin
            case (cmd.char_code)
                CHAR_NL:
                begin
                    op_in.kind = OP_NEWLINE;
                end
                CHAR_BS:
                begin
                    op_in.kind = OP_BACKSPACE;
                end
                CHAR_TAB:
                begin
                    op_in.char_code = CHAR_SPACE;
                    op_in.count     = (tab_width > TAB_MAX) ? TAB_MAX : tab_width;
                end
                default:
                begin
                    op_in.kind = OP_PUT;
                end
            endcase
        end
    end

    // Two-entry queue toward the back end
    assign cmd_ready = (q_count_reg != Q_FULL) && !hold;
    assign push      = cmd_valid && cmd_ready;
    assign op_valid  = (q_count_reg != 2'd0);
    assign op        = q_mem_reg[q_rd_reg];

    always_comb
    begin
        q_wr_next    = push ? ~q_wr_reg : q_wr_reg;
        q_rd_next    = op_pop ? ~q_rd_reg : q_rd_reg;
        q_count_next = q_count_reg + {1'b0, push} - {1'b0, op_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_reg    <= 1'b0;
            q_rd_reg    <= 1'b0;
            q_count_reg <= 2'd0;
        end
        else
        begin
            q_wr_reg    <= q_wr_next;
            q_rd_reg    <= q_rd_next;
            q_count_reg <= q_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[q_wr_reg] <= op_in;
        end
    end

endmodule

// ===== src/tccw_back.sv =====
module tccw_back
    import tccw_pkg::*;
    #(
        parameter int ROWS    = ROWS_DEF,
        parameter int COLUMNS = COLUMNS_DEF
    )
    (
        input  logic       clk,
        input  logic       rst_n,
        input  logic       op_valid,
        input  op_t        op,
        output logic       op_pop,
        input  logic [7:0] text_attribute,
        output logic       clearing,
        output logic       rsp_valid,
        input  logic       rsp_ready,
        output rsp_item_t  rsp
    );

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (1 << CW);
    localparam int PW    = $clog2(ROWS * COLUMNS);

    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_PUT    = 3'd2;
    localparam logic [2:0] ST_SWEEP  = 3'd3;
    localparam logic [2:0] ST_RDWAIT = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] top_reg, top_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic [7:0]    char_reg, char_next;
    logic          scr_reg, scr_next;
    logic [RW-1:0] sweep_row_reg, sweep_row_next;
    logic [CW-1:0] sweep_col_reg, sweep_col_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_item_t     rsp_reg;

    logic          we;
    logic [AW-1:0] waddr;
    logic [15:0]   wdata;
    logic [AW-1:0] raddr;
    logic [15:0]   rdata;
    logic          emit;
    logic [15:0]   emit_data;
    logic [PW-1:0] pos_full;

    // Logical row to physical row of the rotating screen store
    function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] lrow,
                                               input logic [RW-1:0] top);
        logic [RW:0] sum;
        sum = {1'b0, lrow} + {1'b0, top};
        if (sum >= (RW+1)'(ROWS))
        begin
            sum = sum - (RW+1)'(ROWS);
        end
        return sum[RW-1:0];
    endfunction

    tccw_ram
        #(
            .WIDTH(16),
            .DEPTH(DEPTH)
        )
    u_screen
        (
            .clk(clk),
            .we(we),
            .waddr(waddr),
            .wdata(wdata),
            .raddr(raddr),
            .rdata(rdata)
        );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        top_next       = top_reg;
        cnt_next       = cnt_reg;
        char_next      = char_reg;
        scr_next       = scr_reg;
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg;
        clr_addr_next  = clr_addr_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = BLANK_CELL;
        raddr          = '0;
        emit           = 1'b0;
        emit_data      = 16'd0;
        op_pop         = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_addr_reg;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (op_valid && (!rsp_valid_reg || rsp_ready))
                begin
                    op_pop   = 1'b1;
                    scr_next = 1'b0;
                    case (op.kind)
                        OP_READ:
                        begin
                            if (op.read_oob)
                            begin
                                emit = 1'b1;
                            end
                            else
                            begin
                                raddr      = {phys_row(RW'(op.read_row), top_reg),
                                              CW'(op.read_col)};
                                state_next = ST_RDWAIT;
                            end
                        end
                        OP_NEWLINE:
                        begin
                            col_next = '0;
                            if (row_reg == LAST_ROW)
                            begin
                                scr_next       = 1'b1;
                                sweep_row_next = top_reg;
                                sweep_col_next = '0;
                                top_next       = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                                cnt_next       = 4'd0;
                                state_next     = ST_SWEEP;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                                emit     = 1'b1;
                            end
                        end
                        OP_BACKSPACE:
                        begin
                            if (col_reg != '0 || row_reg != '0)
                            begin
                                if (col_reg != '0)
                                begin
                                    col_next = col_reg - 1'b1;
                                end
                                else
                                begin
                                    row_next = row_reg - 1'b1;
                                    col_next = LAST_COL;
                                end
                                we    = 1'b1;
                                waddr = {phys_row(row_next, top_reg), col_next};
                            end
                            emit = 1'b1;
                        end
                        default:
                        begin
                            cnt_next   = op.count;
                            char_next  = op.char_code;
                            state_next = ST_PUT;
                        end
                    endcase
                end
            end

            ST_PUT:
            begin
                if (cnt_reg == 4'd0)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    we       = 1'b1;
                    waddr    = {phys_row(row_reg, top_reg), col_reg};
                    wdata    = {text_attribute, char_reg};
                    cnt_next = cnt_reg - 4'd1;
                    if (col_reg == LAST_COL)
                    begin
                        col_next = '0;
                        if (row_reg == LAST_ROW)
                        begin
                            // bottom row passed: rotate and blank the new bottom row
                            scr_next       = 1'b1;
                            sweep_row_next = top_reg;
                            sweep_col_next = '0;
                            top_next       = (top_reg == LAST_ROW) ? '0 : top_reg + 1'b1;
                            state_next     = ST_SWEEP;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                    // last cell without scroll finishes at once
                    if (state_next == ST_PUT && cnt_reg == 4'd1)
                    begin
                        emit       = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SWEEP:
            begin
                we    = 1'b1;
                waddr = {sweep_row_reg, sweep_col_reg};
                if (sweep_col_reg == LAST_COL)
                begin
                    state_next = ST_PUT;
                end
                else
                begin
                    sweep_col_next = sweep_col_reg + 1'b1;
                end
            end

            ST_RDWAIT:
            begin
                emit       = 1'b1;
                emit_data  = rdata;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result assembly
    assign pos_full       = PW'(row_next) * PW'(COLUMNS) + PW'(col_next);
    assign rsp_valid_next = emit ? 1'b1 : (rsp_valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            row_reg       <= '0;
            col_reg       <= '0;
            top_reg       <= '0;
            cnt_reg       <= 4'd0;
            char_reg      <= 8'd0;
            scr_reg       <= 1'b0;
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
            clr_addr_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            top_reg       <= top_next;
            cnt_reg       <= cnt_next;
            char_reg      <= char_next;
            scr_reg       <= scr_next;
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
            clr_addr_reg  <= clr_addr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            rsp_reg.cursor_row      <= 5'(row_next);
            rsp_reg.cursor_col      <= 7'(col_next);
            rsp_reg.cursor_position <= 11'(pos_full);
            rsp_reg.read_data       <= emit_data;
            rsp_reg.scrolled        <= scr_next;
        end
    end

    assign clearing  = (state_reg == ST_CLEAR);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== src/text_console_char_writer_core.sv =====
// Character-cell console writer.
// cmd channel (valid/ready): func 0 puts char_code at the cursor (newline, backspace
// and tab handled), func 1 reads the cell at read_row/read_col. Every transaction
// gives one rsp transaction with the cursor after it, its linear position, the read
// word (0 for puts or out-of-range reads) and a scrolled flag.
// APB port: offset 0x0 text_attribute, offset 0x4 tab_width; pready is always high.
// With the back end idle, a plain char goes from IDLE through PUT and an in-range
// read through RDWAIT before its report; out-of-range reads, backspaces and
// newlines report straight from IDLE, a tab writes its spaces in PUT, and a scroll
// first blanks the new bottom row in SWEEP (screen rows rotate, no copy). All of this
// is bound by the single write port of the screen RAM driven by the back-end
// sequencer; a two-entry queue lets cmd run ahead.
// Reset: cursor to origin, registers to defaults, then a clearing pass over all
// ROWS * 2^clog2(COLUMNS) words of the screen RAM (3200 for 80x25) with cmd_ready low.
// If rsp_ready stays low the result holds in the output register, the queue fills,
// and cmd_ready drops after two more transactions.
module text_console_char_writer_core
    import tccw_pkg::*;
    #(
        parameter int ROWS    = ROWS_DEF,
        parameter int COLUMNS = COLUMNS_DEF
    )
    (
        input  logic               clk,
        input  logic               rst_n,
        input  logic               psel,
        input  logic               penable,
        input  logic               pwrite,
        input  logic [PADDR_W-1:0] paddr,
        input  logic [PDATA_W-1:0] pwdata,
        output logic [PDATA_W-1:0] prdata,
        output logic               pready,
        input  logic               cmd_valid,
        output logic               cmd_ready,
        input  cmd_item_t          cmd,
        output logic               rsp_valid,
        input  logic               rsp_ready,
        output rsp_item_t          rsp
    );

    logic [7:0] attr_reg, attr_next;
    logic [3:0] tab_reg, tab_next;
    logic       cfg_we;
    logic       clearing;
    logic       op_valid;
    logic       op_pop;
    op_t        op;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;

    always_comb
    begin
        attr_next = attr_reg;
        tab_next  = tab_reg;
        if (cfg_we)
        begin
            case (paddr[2])
                REG_ATTR: attr_next = pwdata[7:0];
                REG_TAB:  tab_next  = pwdata[3:0];
                default:  attr_next = attr_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ATTR: prdata = PDATA_W'(attr_reg);
            REG_TAB:  prdata = PDATA_W'(tab_reg);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
            tab_reg  <= TAB_RESET;
        end
        else
        begin
            attr_reg <= attr_next;
            tab_reg  <= tab_next;
        end
    end

    tccw_front
        #(
            .ROWS(ROWS),
            .COLUMNS(COLUMNS)
        )
    u_front
        (
            .clk(clk),
            .rst_n(rst_n),
            .cmd_valid(cmd_valid),
            .cmd_ready(cmd_ready),
            .cmd(cmd),
            .tab_width(tab_reg),
            .hold(clearing),
            .op_valid(op_valid),
            .op(op),
            .op_pop(op_pop)
        );

    tccw_back
        #(
            .ROWS(ROWS),
            .COLUMNS(COLUMNS)
        )
    u_back
        (
            .clk(clk),
            .rst_n(rst_n),
            .op_valid(op_valid),
            .op(op),
            .op_pop(op_pop),
            .text_attribute(attr_reg),
            .clearing(clearing),
            .rsp_valid(rsp_valid),
            .rsp_ready(rsp_ready),
            .rsp(rsp)
        );

endmodule

// ===== src/tccw_checker.sv =====
module tccw_checker
    import tccw_pkg::*;
    #(
        parameter int ROWS    = ROWS_DEF,
        parameter int COLUMNS = COLUMNS_DEF
    )
    (
        input logic      clk,
        input logic      rst_n,
        input logic      cmd_valid,
        input logic      cmd_ready,
        input cmd_item_t cmd,
        input logic      rsp_valid,
        input logic      rsp_ready,
        input rsp_item_t rsp
    );

    // Waiting command holds its payload
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("cmd changed while waiting");

    // Stalled result holds its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    // Screen clearing pass blocks commands right after reset
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !cmd_ready)
        else $error("cmd accepted during clearing pass");

    // Linear position matches row and column
    a_position: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ROWS <= 32 && COLUMNS <= 128 |->
            rsp.cursor_position == 11'(32'(rsp.cursor_row) * COLUMNS + 32'(rsp.cursor_col)))
        else $error("cursor_position inconsistent");

    // A scroll always leaves the cursor on the bottom row
    a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.scrolled |-> rsp.cursor_row == 5'(ROWS - 1))
        else $error("scrolled with cursor off the bottom row");

endmodule

bind text_console_char_writer_core tccw_checker
    #(
        .ROWS(ROWS),
        .COLUMNS(COLUMNS)
    )
u_checker
    (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

// ===== bench/console_checker.sv =====
module console_checker
    import tccw_pkg::*;
    (
        input  logic               clk,
        input  logic               rst_n,
        input  logic               psel,
        input  logic               penable,
        input  logic               pwrite,
        input  logic [PADDR_W-1:0] paddr,
        input  logic [PDATA_W-1:0] pwdata,
        input  logic               pready,
        input  logic               cmd_valid,
        input  logic               cmd_ready,
        input  cmd_item_t          cmd,
        input  logic               rsp_valid,
        input  logic               rsp_ready,
        input  rsp_item_t          rsp,
        output int                 fail_count,
        output int                 open_count
    );

    localparam int ROWS    = ROWS_DEF;
    localparam int COLUMNS = COLUMNS_DEF;
    localparam int CELLS   = ROWS * COLUMNS;

    // Shadow copy of the screen, cursor and registers
    logic [15:0] screen [CELLS];
    int unsigned cur_row;
    int unsigned cur_col;
    logic [7:0]  attr;
    logic [3:0]  tab_w;

    // Cursor reports still owed by the block, oldest first
    rsp_item_t   owed_reports [$];
    rsp_item_t   want;

    // Step down one row; past the bottom the screen moves up and the last row blanks
    function automatic logic advance_row();
        cur_row++;
        if (cur_row < ROWS)
            return 1'b0;
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen[i] = BLANK_CELL;
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    // Store one byte at the cursor and move right, wrapping at the line end
    function automatic logic place_char(input logic [7:0] code);
        screen[cur_row * COLUMNS + cur_col] = {attr, code};
        cur_col++;
        if (cur_col >= COLUMNS)
        begin
            cur_col = 0;
            return advance_row();
        end
        return 1'b0;
    endfunction

    // Apply one command to the shadow screen and build the cursor report it yields
    function automatic rsp_item_t console_step(input cmd_item_t c);
        rsp_item_t   r;
        int unsigned spaces;
        r = '0;
        if (c.func == FUNC_READ)
        begin
            if (c.read_row < ROWS && c.read_col < COLUMNS)
                r.read_data = screen[c.read_row * COLUMNS + c.read_col];
        end
        else if (c.char_code == CHAR_NL)
        begin
            cur_col = 0;
            r.scrolled = advance_row();
        end
        else if (c.char_code == CHAR_BS)
        begin
            // nothing happens at the origin
            if (cur_col > 0 || cur_row > 0)
            begin
                if (cur_col > 0)
                    cur_col--;
                else
                begin
                    cur_row--;
                    cur_col = COLUMNS - 1;
                end
                screen[cur_row * COLUMNS + cur_col] = BLANK_CELL;
            end
        end
        else if (c.char_code == CHAR_TAB)
        begin
            spaces = 32'((tab_w > TAB_MAX) ? TAB_MAX : tab_w);
            for (int i = 0; i < spaces; i++)
                r.scrolled |= place_char(CHAR_SPACE);
        end
        else
            r.scrolled = place_char(c.char_code);
        r.cursor_row      = 5'(cur_row);
        r.cursor_col      = 7'(cur_col);
        r.cursor_position = 11'(cur_row * COLUMNS + cur_col);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v, got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    // Track register writes, predict on accepted commands, compare accepted reports
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CELLS; i++)
                screen[i] = BLANK_CELL;
            cur_row = 0;
            cur_col = 0;
            attr    = ATTR_RESET;
            tab_w   = TAB_RESET;
            owed_reports.delete();
            fail_count = 0;
            open_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_ATTR)
                    attr = pwdata[7:0];
                else if (paddr[PADDR_W-1:2] == REG_TAB)
                    tab_w = pwdata[3:0];
            end
            if (cmd_valid && cmd_ready)
                owed_reports.push_back(console_step(cmd));
            if (rsp_valid && rsp_ready)
            begin
                if (owed_reports.size() == 0)
                begin
                    $error("response transaction with no command waiting: %h", rsp);
                    fail_count++;
                end
                else
                begin
                    want = owed_reports.pop_front();
                    check_field("cursor_row", 32'(want.cursor_row), 32'(rsp.cursor_row));
                    check_field("cursor_col", 32'(want.cursor_col), 32'(rsp.cursor_col));
                    check_field("cursor_position", 32'(want.cursor_position),
                                32'(rsp.cursor_position));
                    check_field("read_data", 32'(want.read_data), 32'(rsp.read_data));
                    check_field("scrolled", 32'(want.scrolled), 32'(rsp.scrolled));
                end
            end
            open_count = owed_reports.size();
        end
    end

endmodule

// ===== bench/text_console_char_writer_core_tb.sv =====
module text_console_char_writer_core_tb;
    import tccw_pkg::*;

    localparam int ROWS         = ROWS_DEF;
    localparam int COLUMNS      = COLUMNS_DEF;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 170;
    // idle margin after the last report before touching the registers
    localparam int SETTLE       = 4 * COLUMNS;
    localparam int CYCLE_LIMIT  = 800000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               cmd_valid;
    logic               cmd_ready;
    cmd_item_t          cmd;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_item_t          rsp;

    int                 fail_count;
    int                 open_count;
    int unsigned        cycle_count = 0;
    bit                 send_idle;
    bit                 recv_idle;

    text_console_char_writer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    console_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .fail_count (fail_count),
        .open_count (open_count)
    );

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("text_console_char_writer_core: mismatch");
            $finish;
        end
    end

    // Response side back-pressure
    always @(posedge clk)
        rsp_ready <= !(recv_idle && $urandom_range(0, 99) < 36);

    function automatic cmd_item_t put_item(input logic [7:0] code);
        cmd_item_t c;
        c = '0;
        c.func      = FUNC_PUT;
        c.char_code = code;
        return c;
    endfunction

    function automatic cmd_item_t read_item(input logic [4:0] row, input logic [6:0] col);
        cmd_item_t c;
        c = '0;
        c.func     = FUNC_READ;
        c.read_row = row;
        c.read_col = col;
        return c;
    endfunction

    // Text with reads and control bytes mixed in; nl_pct sets the typical line length
    function automatic cmd_item_t random_item(input int unsigned nl_pct);
        cmd_item_t   c;
        int unsigned pick;
        c.func      = FUNC_PUT;
        c.char_code = 8'($urandom_range(0, 255));
        c.read_row  = 5'($urandom_range(0, 31));
        c.read_col  = 7'($urandom_range(0, 127));
        pick = $urandom_range(0, 99);
        if (pick < 18)
        begin
            c.func = FUNC_READ;
            // a few reads stay fully random and mostly fall off the screen
            if ($urandom_range(0, 9) != 0)
            begin
                c.read_row = 5'($urandom_range(0, ROWS - 1));
                c.read_col = 7'($urandom_range(0, COLUMNS - 1));
            end
        end
        else if (pick < 18 + nl_pct)
            c.char_code = CHAR_NL;
        else if (pick < 26 + nl_pct)
            c.char_code = CHAR_BS;
        else if (pick < 36 + nl_pct)
            c.char_code = CHAR_TAB;
        return c;
    endfunction

    // One command transaction, with a random gap in front of it while send_idle is set
    task automatic send_cmd(input cmd_item_t c);
        while (send_idle && $urandom_range(0, 99) < 36)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        do
            @(posedge clk);
        while (!cmd_ready);
    endtask

    // APB write: setup cycle, then access cycle; the caller ends the transfer
    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
    endtask

    // Stop sending, wait for all reports, then idle a while
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] attr, input logic [3:0] tab);
        drain();
        write_reg(REG_ATTR, {24'd0, attr});
        write_reg(REG_TAB, {28'd0, tab});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A byte and a tab under the new settings, then read back a cell of row 1
    task automatic probe_config(input logic [7:0] attr, input logic [3:0] tab);
        set_config(attr, tab);
        send_cmd(put_item(8'($urandom_range(0, 255))));
        send_cmd(put_item(CHAR_TAB));
        send_cmd(read_item(5'd1, 7'($urandom_range(0, 15))));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        cmd_valid = 1'b0;
        cmd       = '0;
        send_idle = 1'b1;
        recv_idle = 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset settings, cursor starts at the origin
        send_cmd(put_item(CHAR_BS));
        send_cmd(read_item(5'd0, 7'd0));
        send_cmd(put_item(8'h41));
        send_cmd(put_item(8'hFF));
        send_cmd(put_item(8'h00));
        send_cmd(put_item(8'h0D));
        send_cmd(put_item(CHAR_BS));
        send_cmd(read_item(5'd0, 7'd2));
        send_cmd(put_item(CHAR_TAB));
        send_cmd(put_item(CHAR_NL));
        send_cmd(put_item(CHAR_BS));
        send_cmd(read_item(5'd24, 7'd79));
        send_cmd(read_item(5'd31, 7'd127));
        send_cmd(read_item(5'd25, 7'd0));
        send_cmd(read_item(5'd0, 7'd80));

        // Directed: register extremes, zero and oversize tab widths
        probe_config(8'h00, 4'd0);
        probe_config(8'hFF, 4'd15);
        probe_config(8'h5A, 4'd1);
        probe_config(8'hA5, 4'd8);

        // Random phases alternate short and long lines; one phase runs with no idling
        for (int phase = 0; phase < PHASES; phase++)
        begin
            set_config(8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
            send_idle <= (phase != 2);
            recv_idle <= (phase != 2);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_cmd(random_item((phase % 2 == 0) ? 15 : 2));
        end
        send_idle <= 1'b1;
        recv_idle <= 1'b1;

        drain();
        if (fail_count == 0 && open_count == 0)
            $display("text_console_char_writer_core: match");
        else
            $display("text_console_char_writer_core: mismatch");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tccw_pkg.sv
src/tccw_ram.sv
src/tccw_front.sv
src/tccw_back.sv
src/text_console_char_writer_core.sv
src/tccw_checker.sv
bench/console_checker.sv
bench/text_console_char_writer_core_tb.sv
